// ===== rtl/modexp_pkg.sv =====
// ----------------------------------------------------------------------------
// modexp_pkg
// Shared types, step labels and the control store of the modular
// exponentiation sequencer.
// ----------------------------------------------------------------------------
package modexp_pkg;

   // default word width of base, exponent, modulus and result
   localparam int DEFAULT_DATA_WIDTH = 64;

   // step counter width
   localparam int STEP_W = 5;

   // datapath operation of one step
   typedef enum logic [3:0] {
      OP_NOP,
      OP_LOAD,
      OP_LD_ACC,
      OP_LD_SQ,
      OP_SUB_Y,
      OP_REM_STEP,
      OP_REM_DONE,
      OP_MUL_STEP,
      OP_WB_ACC,
      OP_WB_SQ,
      OP_SHR_E,
      OP_PUSH
   } op_type;

   // jump condition of one step
   typedef enum logic [3:0] {
      CND_NEVER,
      CND_ALWAYS,
      CND_NOT_START,
      CND_NOT_EBIT,
      CND_Y_LT_M,
      CND_NOT_BIG,
      CND_NOT_LAST,
      CND_PX_ZERO,
      CND_PX_MORE,
      CND_E_LAST,
      CND_OUT_BUSY
   } cond_type;

   // one control word
   typedef struct packed {
      op_type              op;
      cond_type            cond;
      logic [STEP_W-1:0]   target;
   } uword_type;

   // step labels
   localparam logic [STEP_W-1:0] STEP_WAIT      = 5'd0;
   localparam logic [STEP_W-1:0] STEP_TEST      = 5'd1;
   localparam logic [STEP_W-1:0] STEP_LD_A      = 5'd2;
   localparam logic [STEP_W-1:0] STEP_CHK_A     = 5'd3;
   localparam logic [STEP_W-1:0] STEP_BIG_A     = 5'd4;
   localparam logic [STEP_W-1:0] STEP_SUB_A     = 5'd5;
   localparam logic [STEP_W-1:0] STEP_REM_A     = 5'd6;
   localparam logic [STEP_W-1:0] STEP_RDN_A     = 5'd7;
   localparam logic [STEP_W-1:0] STEP_MZ_A      = 5'd8;
   localparam logic [STEP_W-1:0] STEP_MUL_A     = 5'd9;
   localparam logic [STEP_W-1:0] STEP_WB_A      = 5'd10;
   localparam logic [STEP_W-1:0] STEP_SHIFT     = 5'd11;
   localparam logic [STEP_W-1:0] STEP_LD_S      = 5'd12;
   localparam logic [STEP_W-1:0] STEP_CHK_S     = 5'd13;
   localparam logic [STEP_W-1:0] STEP_BIG_S     = 5'd14;
   localparam logic [STEP_W-1:0] STEP_SUB_S     = 5'd15;
   localparam logic [STEP_W-1:0] STEP_REM_S     = 5'd16;
   localparam logic [STEP_W-1:0] STEP_RDN_S     = 5'd17;
   localparam logic [STEP_W-1:0] STEP_MZ_S      = 5'd18;
   localparam logic [STEP_W-1:0] STEP_MUL_S     = 5'd19;
   localparam logic [STEP_W-1:0] STEP_WB_S      = 5'd20;
   localparam logic [STEP_W-1:0] STEP_DONE      = 5'd21;
   localparam logic [STEP_W-1:0] STEP_RETURN    = 5'd22;
   localparam logic [STEP_W-1:0] STEP_LAST      = STEP_RETURN;

   // control store
   function automatic uword_type ucode_rom(input logic [STEP_W-1:0] step);
      uword_type w;
      w = '{op: OP_NOP, cond: CND_ALWAYS, target: STEP_WAIT};
      case (step)
         // wait for a request, load operands on accept
         STEP_WAIT:   w = '{op: OP_LOAD,     cond: CND_NOT_START, target: STEP_WAIT};
         STEP_TEST:   w = '{op: OP_NOP,      cond: CND_NOT_EBIT,  target: STEP_SHIFT};
         // acc = acc * sq mod m
         STEP_LD_A:   w = '{op: OP_LD_ACC,   cond: CND_NEVER,     target: STEP_WAIT};
         STEP_CHK_A:  w = '{op: OP_NOP,      cond: CND_Y_LT_M,    target: STEP_MZ_A};
         STEP_BIG_A:  w = '{op: OP_NOP,      cond: CND_NOT_BIG,   target: STEP_REM_A};
         STEP_SUB_A:  w = '{op: OP_SUB_Y,    cond: CND_ALWAYS,    target: STEP_MZ_A};
         STEP_REM_A:  w = '{op: OP_REM_STEP, cond: CND_NOT_LAST,  target: STEP_REM_A};
         STEP_RDN_A:  w = '{op: OP_REM_DONE, cond: CND_NEVER,     target: STEP_WAIT};
         STEP_MZ_A:   w = '{op: OP_NOP,      cond: CND_PX_ZERO,   target: STEP_WB_A};
         STEP_MUL_A:  w = '{op: OP_MUL_STEP, cond: CND_PX_MORE,   target: STEP_MUL_A};
         STEP_WB_A:   w = '{op: OP_WB_ACC,   cond: CND_NEVER,     target: STEP_WAIT};
         // next exponent bit, finish when none left
         STEP_SHIFT:  w = '{op: OP_SHR_E,    cond: CND_E_LAST,    target: STEP_DONE};
         // sq = sq * sq mod m
         STEP_LD_S:   w = '{op: OP_LD_SQ,    cond: CND_NEVER,     target: STEP_WAIT};
         STEP_CHK_S:  w = '{op: OP_NOP,      cond: CND_Y_LT_M,    target: STEP_MZ_S};
         STEP_BIG_S:  w = '{op: OP_NOP,      cond: CND_NOT_BIG,   target: STEP_REM_S};
         STEP_SUB_S:  w = '{op: OP_SUB_Y,    cond: CND_ALWAYS,    target: STEP_MZ_S};
         STEP_REM_S:  w = '{op: OP_REM_STEP, cond: CND_NOT_LAST,  target: STEP_REM_S};
         STEP_RDN_S:  w = '{op: OP_REM_DONE, cond: CND_NEVER,     target: STEP_WAIT};
         STEP_MZ_S:   w = '{op: OP_NOP,      cond: CND_PX_ZERO,   target: STEP_WB_S};
         STEP_MUL_S:  w = '{op: OP_MUL_STEP, cond: CND_PX_MORE,   target: STEP_MUL_S};
         STEP_WB_S:   w = '{op: OP_WB_SQ,    cond: CND_ALWAYS,    target: STEP_TEST};
         // hand the result to the output register
         STEP_DONE:   w = '{op: OP_PUSH,     cond: CND_OUT_BUSY,  target: STEP_DONE};
         STEP_RETURN: w = '{op: OP_NOP,      cond: CND_ALWAYS,    target: STEP_WAIT};
         default:     w = '{op: OP_NOP,      cond: CND_ALWAYS,    target: STEP_WAIT};
      endcase
      return w;
   endfunction

endpackage

// ===== rtl/modular_exponentiation_64_unit.sv =====
// ----------------------------------------------------------------------------
// modular_exponentiation_64_unit
// Computes base_value ** exponent mod modulus with right-to-left
// square-and-multiply, driven by a small microcoded sequencer.
//
// One request at a time. Each exponent bit up to the highest set one costs a
// test and a shift step, a modular product when the bit is set and a squaring
// when higher bits remain. A product loads its operands, checks the
// multiplicand, runs one shift-and-add step per multiplier bit and writes
// back. A multiplicand not below the modulus is first brought into range by
// the single subtraction, or, when the modulus is below half the range, by
// the one-bit-per-cycle remainder unit; only the first product and the first
// squaring can see an unreduced multiplicand. The shift-and-add steps set
// the length of a request. The result sits in an output register, so the
// next request is taken while it waits. A zero exponent returns 1; a zero
// modulus acts as 2**DATA_WIDTH.
// ----------------------------------------------------------------------------
module modular_exponentiation_64_unit
   import modexp_pkg::*;
#(
   parameter int DATA_WIDTH = DEFAULT_DATA_WIDTH
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // configuration: modulus
   input  logic                                   csr_wr_en,
   input  logic [DATA_WIDTH-1:0]                  csr_wdata,
   // request channel
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // tdata fields from bit 0: base_value, exponent
   input  logic [((2*DATA_WIDTH+7)/8)*8-1:0]      req_tdata,
   // response channel
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // tdata fields from bit 0: power_result
   output logic [((DATA_WIDTH+7)/8)*8-1:0]        rsp_tdata
);

   localparam int W     = DATA_WIDTH;
   localparam int CNT_W = $clog2(DATA_WIDTH);
   localparam int RSP_W = ((DATA_WIDTH+7)/8)*8;

   // registers
   logic [STEP_W-1:0] upc_ff,  upc_in;
   logic [W-1:0]      mod_ff;
   logic [W-1:0]      e_ff,    e_in;
   logic [W-1:0]      acc_ff,  acc_in;
   logic [W-1:0]      sq_ff,   sq_in;
   logic [W-1:0]      px_ff,   px_in;
   logic [W-1:0]      py_ff,   py_in;
   logic [W-1:0]      pa_ff,   pa_in;
   logic [W-1:0]      rem_ff,  rem_in;
   logic [CNT_W-1:0]  cnt_ff,  cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [W-1:0]      rsp_data_ff,  rsp_data_in;

   uword_type uw;
   logic [W:0] m_ext;
   logic       take_jump;
   logic       out_busy;

   // datapath intermediates
   logic [W:0]   add_pa_sum,  add_pa_sub;
   logic [W:0]   add_py_sum,  add_py_sub;
   logic [W-1:0] pa_mod, py_dbl;
   logic [W:0]   rem_shift, rem_sub;
   logic [W-1:0] rem_step;
   logic [W:0]   py_sub;

   // modulus with zero standing for 2**W
   assign m_ext = {(mod_ff == '0), mod_ff};

   assign uw         = ucode_rom(upc_ff);
   assign req_tready = (uw.op == OP_LOAD);
   assign out_busy   = rsp_valid_ff && !rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'(rsp_data_ff);

   // modular adders for the shift-and-add product
   always_comb begin
      add_pa_sum = {1'b0, pa_ff} + {1'b0, py_ff};
      add_pa_sub = add_pa_sum - m_ext;
      pa_mod     = (add_pa_sum >= m_ext) ? add_pa_sub[W-1:0] : add_pa_sum[W-1:0];
      add_py_sum = {1'b0, py_ff} + {1'b0, py_ff};
      add_py_sub = add_py_sum - m_ext;
      py_dbl     = (add_py_sum >= m_ext) ? add_py_sub[W-1:0] : add_py_sum[W-1:0];
   end

   // one restoring remainder step and the single subtraction
   always_comb begin
      rem_shift = {rem_ff, py_ff[W-1]};
      rem_sub   = rem_shift - m_ext;
      rem_step  = (rem_shift >= m_ext) ? rem_sub[W-1:0] : rem_shift[W-1:0];
      py_sub    = {1'b0, py_ff} - m_ext;
   end

   // jump condition
   always_comb begin
      case (uw.cond)
         CND_NEVER:     take_jump = 1'b0;
         CND_ALWAYS:    take_jump = 1'b1;
         CND_NOT_START: take_jump = !req_tvalid;
         CND_NOT_EBIT:  take_jump = !e_ff[0];
         CND_Y_LT_M:    take_jump = ({1'b0, py_ff} < m_ext);
         CND_NOT_BIG:   take_jump = !mod_ff[W-1];
         CND_NOT_LAST:  take_jump = (cnt_ff != CNT_W'(W-1));
         CND_PX_ZERO:   take_jump = (px_ff == '0);
         CND_PX_MORE:   take_jump = (px_ff[W-1:1] != '0);
         CND_E_LAST:    take_jump = (e_ff[W-1:1] == '0);
         CND_OUT_BUSY:  take_jump = out_busy;
         default:       take_jump = 1'b0;
      endcase
   end

   // next step and datapath updates
   always_comb begin
      upc_in       = take_jump ? uw.target : upc_ff + 1'b1;
      e_in         = e_ff;
      acc_in       = acc_ff;
      sq_in        = sq_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      pa_in        = pa_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      case (uw.op)
         OP_LOAD: begin
            if (req_tvalid) begin
               sq_in  = req_tdata[W-1:0];
               e_in   = req_tdata[2*W-1:W];
               acc_in = W'(1);
            end
         end
         OP_LD_ACC: begin
            px_in  = acc_ff;
            py_in  = sq_ff;
            pa_in  = '0;
            rem_in = '0;
            cnt_in = '0;
         end
         OP_LD_SQ: begin
            px_in  = sq_ff;
            py_in  = sq_ff;
            pa_in  = '0;
            rem_in = '0;
            cnt_in = '0;
         end
         OP_SUB_Y: begin
            py_in = py_sub[W-1:0];
         end
         OP_REM_STEP: begin
            rem_in = rem_step;
            py_in  = {py_ff[W-2:0], 1'b0};
            cnt_in = cnt_ff + 1'b1;
         end
         OP_REM_DONE: begin
            py_in = rem_ff;
         end
         OP_MUL_STEP: begin
            if (px_ff[0]) begin
               pa_in = pa_mod;
            end
            px_in = {1'b0, px_ff[W-1:1]};
            py_in = py_dbl;
         end
         OP_WB_ACC: begin
            acc_in = pa_ff;
         end
         OP_WB_SQ: begin
            sq_in = pa_ff;
         end
         OP_SHR_E: begin
            e_in = {1'b0, e_ff[W-1:1]};
         end
         OP_PUSH: begin
            if (!out_busy) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = acc_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff       <= STEP_WAIT;
         rsp_valid_ff <= 1'b0;
         mod_ff       <= W'(1);
      end else begin
         upc_ff       <= upc_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            mod_ff <= csr_wdata;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      e_ff        <= e_in;
      acc_ff      <= acc_in;
      sq_ff       <= sq_in;
      px_ff       <= px_in;
      py_ff       <= py_in;
      pa_ff       <= pa_in;
      rem_ff      <= rem_in;
      cnt_ff      <= cnt_in;
      rsp_data_ff <= rsp_data_in;
   end

   // a new response only follows the final step
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(upc_ff) == STEP_DONE)
      else $error("response raised outside the final step");

   // step counter stays inside the program
   a_upc_range: assert property (@(posedge clock) disable iff (reset)
      upc_ff <= STEP_LAST)
      else $error("step counter beyond program");

   // accepted request starts the bit loop with acc = 1
   a_accept_start: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (upc_ff == STEP_TEST) && (acc_ff == W'(1)))
      else $error("request accept did not start the bit loop");

   // exponent moves one bit per shift step
   a_exp_shift: assert property (@(posedge clock) disable iff (reset)
      (upc_ff == STEP_SHIFT) |=> e_ff == {1'b0, $past(e_ff[W-1:1])})
      else $error("exponent shift mismatch");

endmodule
